>>> sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared types, codes and helpers of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

	// default geometry of the pool
	localparam int LEVELS_DEF     = 8;
	localparam int LEAF_BYTES_DEF = 128;

	// item field widths
	localparam int MODE_W   = 1;
	localparam int SIZE_W   = 16;
	localparam int OFFSET_W = 15;
	localparam int STATUS_W = 2;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

	// tree state is packed 32 nodes to a memory row
	localparam int ROW_BITS  = 32;
	localparam int ROW_IDX_W = 5;
	localparam int ROW_SHIFT = 5;

	typedef struct packed {
		logic [ROW_BITS-1:0] split;
		logic [ROW_BITS-1:0] free;
	} row_t;

	// row content after reset: only the root (node 0 of row 0) is free
	localparam row_t ROOT_ROW = '{split: '0, free: ROW_BITS'(1)};

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_BLOCK = 2'd1,
		STATUS_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ALLOC_START,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_OFFS,
		S_SPLIT_RD,
		S_SPLIT_WR,
		S_BUDDY_RD,
		S_BUDDY_WR,
		S_FREE_START,
		S_FIND_RD,
		S_FIND_CHK,
		S_MERGE_RD,
		S_MERGE_CHK,
		S_PARENT_RD,
		S_PARENT_WR,
		S_MARK_RD,
		S_MARK_WR,
		S_DONE
	} state_t;

	// index of the lowest set bit, 0 when none is set
	function automatic logic [ROW_IDX_W-1:0] first_set(input logic [ROW_BITS-1:0] v);
		logic [ROW_IDX_W-1:0] idx;
		idx = '0;
		for (int i = ROW_BITS - 1; i >= 0; i--) begin
			if (v[i]) idx = ROW_IDX_W'(i);
		end
		return idx;
	endfunction

endpackage

>>> sv/bba_req_if.sv
// ----------------------------------------------------------------------------
// bba_req_if
// request channel: allocate or free item
// ----------------------------------------------------------------------------
interface bba_req_if;

	logic                          valid;
	logic                          ready;
	logic [bba_pkg::MODE_W-1:0]    mode;
	logic [bba_pkg::SIZE_W-1:0]    request_size;
	logic [bba_pkg::OFFSET_W-1:0]  free_offset;

	modport source (output valid, output mode, output request_size, output free_offset,
		input ready);
	modport sink (input valid, input mode, input request_size, input free_offset,
		output ready);

endinterface

>>> sv/bba_rsp_if.sv
// ----------------------------------------------------------------------------
// bba_rsp_if
// response channel: block offset and status item
// ----------------------------------------------------------------------------
interface bba_rsp_if;

	logic                          valid;
	logic                          ready;
	logic [bba_pkg::OFFSET_W-1:0]  block_offset;
	logic [bba_pkg::STATUS_W-1:0]  status;

	modport source (output valid, output block_offset, output status, input ready);
	modport sink (input valid, input block_offset, input status, output ready);

endinterface

>>> sv/bba_tree_mem.sv
// ----------------------------------------------------------------------------
// bba_tree_mem
// row memory of free and split bits, one write and one registered read port
// ----------------------------------------------------------------------------
module bba_tree_mem #(
	parameter int ROWS   = 8,
	parameter int ADDR_W = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  bba_pkg::row_t       wdata,
	input  logic [ADDR_W-1:0]   raddr,
	output bba_pkg::row_t       rdata
);
	import bba_pkg::*;

	row_t              mem_q [ROWS];
	row_t              rd_q;
	logic [ROWS-1:0]   row_valid_q;
	logic              rvalid_q;
	logic [ADDR_W-1:0] raddr_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rd_q    <= mem_q[raddr];
		raddr_q <= raddr;
	end

	// rows never written read as their reset content
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_q    <= 1'b0;
		end else begin
			if (we) row_valid_q[waddr] <= 1'b1;
			rvalid_q <= row_valid_q[raddr];
		end
	end

	assign rdata = rvalid_q ? rd_q : ((raddr_q == '0) ? ROOT_ROW : row_t'('0));

endmodule

>>> sv/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// binary buddy allocator: sequencer over a packed free/split tree memory
// ----------------------------------------------------------------------------
//
// channel  dir  handshake      payload
// req      in   valid/ready    mode, request_size, free_offset
// rsp      out  valid/ready    block_offset, status
//
// one item at a time: req.ready is high only in idle, each tree write is a read-modify-write
// allocate runs start, scan read/check per row, offset, split/buddy read-writes per level split, mark, finish
// free runs start, find per level, merge check + parent write per merge until a held buddy, mark, finish
// errors go to finish right after the check that finds them
// reset needs no clearing pass: per-row valid bits give the reset content
// finish waits while the rsp register holds an item the sink has not taken
//
module buddy_block_allocator #(
	parameter int LEVELS     = bba_pkg::LEVELS_DEF,
	parameter int LEAF_BYTES = bba_pkg::LEAF_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bba_req_if.sink    req,
	bba_rsp_if.source  rsp
);
	import bba_pkg::*;

	// tree geometry
	localparam int NODE_COUNT = (1 << LEVELS) - 1;
	localparam int NODE_W     = LEVELS;
	localparam int ROWS       = (NODE_COUNT + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LVL_W      = $clog2(LEVELS);
	localparam int LEAF_IW    = LEVELS - 1;
	localparam logic [63:0] POOL_BYTES = 64'(LEAF_BYTES) << (LEVELS - 1);
	localparam int BSZ_W      = $clog2(POOL_BYTES + 64'd1);
	localparam int CMP_W      = (BSZ_W > OFFSET_W) ? BSZ_W : OFFSET_W;
	localparam logic [OFFSET_W-1:0] LEAF_MUL = OFFSET_W'(LEAF_BYTES);
	localparam logic [LVL_W-1:0]    LVL_LAST = LVL_W'(LEVELS - 1);

	function automatic logic [ROW_AW-1:0] row_of(input logic [NODE_W-1:0] n);
		return ROW_AW'(n >> ROW_SHIFT);
	endfunction

	function automatic logic [ROW_IDX_W-1:0] bit_of(input logic [NODE_W-1:0] n);
		return ROW_IDX_W'(n);
	endfunction

	function automatic logic [NODE_W-1:0] first_node(input logic [LVL_W-1:0] l);
		return NODE_W'((32'd1 << l) - 32'd1);
	endfunction

	function automatic logic [NODE_W-1:0] last_node(input logic [LVL_W-1:0] l);
		return NODE_W'((32'd2 << l) - 32'd2);
	endfunction

	// sequencer state and working registers
	state_t               state_q, state_n;
	logic [SIZE_W-1:0]    size_q, size_n;
	logic [OFFSET_W-1:0]  offset_q, offset_n;
	logic [LVL_W-1:0]     want_q, want_n;
	logic [LVL_W-1:0]     lvl_q, lvl_n;
	logic [ROW_AW-1:0]    row_q, row_n;
	logic [NODE_W-1:0]    node_q, node_n;
	logic [OFFSET_W-1:0]  start_q, start_n;
	logic [BSZ_W-1:0]     bsize_q, bsize_n;
	logic                 first_q, first_n;
	logic [OFFSET_W-1:0]  off_q, off_n;
	status_t              status_q, status_n;

	// result register
	logic                 rsp_valid_q;
	logic [OFFSET_W-1:0]  rsp_offset_q;
	logic [STATUS_W-1:0]  rsp_status_q;
	logic                 load_rsp;

	// memory port
	logic                 mem_we;
	logic [ROW_AW-1:0]    mem_waddr;
	row_t                 mem_wdata;
	logic [ROW_AW-1:0]    mem_raddr;
	row_t                 rd_row;

	// size to level
	logic [SIZE_W-1:0]    size_eff;
	logic [LVL_W-1:0]     k_cnt;
	logic [LVL_W-1:0]     want;
	logic                 oversize;

	// level scan
	logic [NODE_W-1:0]    scan_lo, scan_hi;
	logic [ROW_BITS-1:0]  scan_mask;
	logic [ROW_BITS-1:0]  scan_hits;
	logic [NODE_W-1:0]    hit_node;

	// offset and tree walk helpers
	logic [NODE_W-1:0]    idx_in_lvl;
	logic [LEAF_IW-1:0]   leaf_idx;
	logic [NODE_W-1:0]    right_child, left_child, buddy, parent;
	logic [BSZ_W-1:0]     half;
	logic [OFFSET_W-1:0]  diff;
	logic                 go_right;

	bba_tree_mem #(
		.ROWS   (ROWS),
		.ADDR_W (ROW_AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr  (mem_raddr),
		.rdata  (rd_row)
	);

	// deepest level whose block holds the size; zero counts as one leaf
	always_comb begin
		size_eff = (size_q == '0) ? SIZE_W'(1) : size_q;
		k_cnt    = '0;
		for (int j = 0; j < LEVELS - 1; j++) begin
			if ((64'(LEAF_BYTES) << j) < 64'(size_eff)) k_cnt = k_cnt + LVL_W'(1);
		end
		want     = LVL_LAST - k_cnt;
		oversize = 64'(size_eff) > POOL_BYTES;
	end

	// mask the current row down to the nodes of the level being scanned
	always_comb begin
		logic [31:0] g;
		scan_lo = first_node(lvl_q);
		scan_hi = last_node(lvl_q);
		for (int b = 0; b < ROW_BITS; b++) begin
			g = (32'(row_q) << ROW_SHIFT) | 32'(b);
			scan_mask[b] = (g >= 32'(scan_lo)) && (g <= 32'(scan_hi));
		end
		scan_hits = rd_row.free & scan_mask;
		hit_node  = NODE_W'({row_q, first_set(scan_hits)});
	end

	// leaf index of the found block, scaled by the leaf size in S_OFFS
	assign idx_in_lvl  = node_q - first_node(lvl_q);
	assign leaf_idx    = LEAF_IW'(32'(idx_in_lvl) << (LVL_LAST - lvl_q));

	assign right_child = NODE_W'((32'(node_q) << 1) + 32'd2);
	assign left_child  = NODE_W'((32'(node_q) << 1) + 32'd1);
	assign buddy       = node_q[0] ? (node_q + NODE_W'(1)) : (node_q - NODE_W'(1));
	assign parent      = NODE_W'((32'(node_q) - 32'd1) >> 1);

	// free descent: pick the half of the current block that holds the offset
	assign half     = bsize_q >> 1;
	assign diff     = offset_q - start_q;
	assign go_right = CMP_W'(diff) >= CMP_W'(half);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_n;
	end

	always_comb begin
		state_n   = state_q;
		size_n    = size_q;
		offset_n  = offset_q;
		want_n    = want_q;
		lvl_n     = lvl_q;
		row_n     = row_q;
		node_n    = node_q;
		start_n   = start_q;
		bsize_n   = bsize_q;
		first_n   = first_q;
		off_n     = off_q;
		status_n  = status_q;
		mem_we    = 1'b0;
		mem_waddr = row_of(node_q);
		mem_wdata = rd_row;
		mem_raddr = row_of(node_q);
		load_rsp  = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					size_n   = req.request_size;
					offset_n = req.free_offset;
					off_n    = '0;
					state_n  = (req.mode == MODE_ALLOC) ? S_ALLOC_START : S_FREE_START;
				end
			end

			// ---- allocate ----
			S_ALLOC_START: begin
				if (oversize) begin
					status_n = STATUS_NO_BLOCK;
					state_n  = S_DONE;
				end else begin
					want_n  = want;
					lvl_n   = want;
					row_n   = row_of(first_node(want));
					state_n = S_SCAN_RD;
				end
			end

			S_SCAN_RD: begin
				mem_raddr = row_q;
				state_n   = S_SCAN_CHK;
			end

			S_SCAN_CHK: begin
				if (|scan_hits) begin
					node_n  = hit_node;
					state_n = S_OFFS;
				end else if (row_q == row_of(scan_hi)) begin
					if (lvl_q == '0) begin
						// no free block at the wanted or any larger level
						status_n = STATUS_NO_BLOCK;
						state_n  = S_DONE;
					end else begin
						lvl_n   = lvl_q - LVL_W'(1);
						row_n   = row_of(first_node(lvl_q - LVL_W'(1)));
						state_n = S_SCAN_RD;
					end
				end else begin
					row_n   = row_q + ROW_AW'(1);
					state_n = S_SCAN_RD;
				end
			end

			S_OFFS: begin
				off_n   = OFFSET_W'(OFFSET_W'(leaf_idx) * LEAF_MUL);
				first_n = 1'b1;
				state_n = S_SPLIT_RD;
			end

			S_SPLIT_RD: begin
				mem_raddr = row_of(node_q);
				state_n   = S_SPLIT_WR;
			end

			S_SPLIT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = row_of(node_q);
				if (first_q || lvl_q == want_q) mem_wdata.free[bit_of(node_q)] = 1'b0;
				if (lvl_q < want_q) begin
					mem_wdata.split[bit_of(node_q)] = 1'b1;
					state_n = S_BUDDY_RD;
				end else begin
					status_n = STATUS_OK;
					state_n  = S_DONE;
				end
			end

			S_BUDDY_RD: begin
				mem_raddr = row_of(right_child);
				state_n   = S_BUDDY_WR;
			end

			S_BUDDY_WR: begin
				// right half becomes free, walk on into the left half
				mem_we    = 1'b1;
				mem_waddr = row_of(right_child);
				mem_wdata.free[bit_of(right_child)] = 1'b1;
				node_n    = left_child;
				lvl_n     = lvl_q + LVL_W'(1);
				first_n   = 1'b0;
				state_n   = S_SPLIT_RD;
			end

			// ---- free ----
			S_FREE_START: begin
				if (64'(offset_q) >= POOL_BYTES) begin
					status_n = STATUS_BAD_FREE;
					state_n  = S_DONE;
				end else begin
					node_n  = '0;
					lvl_n   = '0;
					start_n = '0;
					bsize_n = BSZ_W'(POOL_BYTES);
					state_n = S_FIND_RD;
				end
			end

			S_FIND_RD: begin
				mem_raddr = row_of(node_q);
				state_n   = S_FIND_CHK;
			end

			S_FIND_CHK: begin
				if (lvl_q < LVL_LAST && rd_row.split[bit_of(node_q)]) begin
					bsize_n = half;
					lvl_n   = lvl_q + LVL_W'(1);
					if (go_right) begin
						start_n = start_q + OFFSET_W'(half);
						node_n  = right_child;
					end else begin
						node_n  = left_child;
					end
					state_n = S_FIND_RD;
				end else if (start_q != offset_q || rd_row.free[bit_of(node_q)]) begin
					// not the start of a block, or the block is already free
					status_n = STATUS_BAD_FREE;
					state_n  = S_DONE;
				end else begin
					state_n = (node_q == '0) ? S_MARK_RD : S_MERGE_RD;
				end
			end

			S_MERGE_RD: begin
				mem_raddr = row_of(buddy);
				state_n   = S_MERGE_CHK;
			end

			S_MERGE_CHK: begin
				if (!rd_row.free[bit_of(buddy)] || rd_row.split[bit_of(buddy)]) begin
					state_n = S_MARK_RD;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = row_of(buddy);
					mem_wdata.free[bit_of(buddy)] = 1'b0;
					node_n    = parent;
					state_n   = S_PARENT_RD;
				end
			end

			S_PARENT_RD: begin
				mem_raddr = row_of(node_q);
				state_n   = S_PARENT_WR;
			end

			S_PARENT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = row_of(node_q);
				mem_wdata.split[bit_of(node_q)] = 1'b0;
				state_n   = (node_q == '0) ? S_MARK_RD : S_MERGE_RD;
			end

			S_MARK_RD: begin
				mem_raddr = row_of(node_q);
				state_n   = S_MARK_WR;
			end

			S_MARK_WR: begin
				mem_we    = 1'b1;
				mem_waddr = row_of(node_q);
				mem_wdata.free[bit_of(node_q)] = 1'b1;
				status_n  = STATUS_OK;
				state_n   = S_DONE;
			end

			// hand the item to the result register once it has room
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_n  = S_IDLE;
				end
			end

			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		size_q   <= size_n;
		offset_q <= offset_n;
		want_q   <= want_n;
		lvl_q    <= lvl_n;
		row_q    <= row_n;
		node_q   <= node_n;
		start_q  <= start_n;
		bsize_q  <= bsize_n;
		first_q  <= first_n;
		off_q    <= off_n;
		status_q <= status_n;
	end

	// result register: off_q stays zero on every error and for free items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       rsp_valid_q <= 1'b0;
		else if (load_rsp) rsp_valid_q <= 1'b1;
		else if (rsp.ready) rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_offset_q <= off_q;
			rsp_status_q <= status_q;
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = rsp_valid_q;
	assign rsp.block_offset = rsp_offset_q;
	assign rsp.status       = rsp_status_q;

endmodule
